>>> rtl/core/rccp_pkg.sv
// Package for the remote-control command line parser.
// Holds character codes, the output offsets, phase and kind codes, the result type and the digit step.
// No dependencies.
`default_nettype none

package rccp_pkg;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_T       = 8'd84;
    localparam logic [7:0] CH_Y       = 8'd89;
    localparam logic [7:0] CH_R       = 8'd82;
    localparam logic [7:0] CH_P       = 8'd80;

    localparam logic [15:0] FIRST_OFFSET = 16'd1000;
    localparam logic [15:0] SECOND_BASE  = 16'd2000;

    localparam logic [2:0] PH_FIRST   = 3'd0;
    localparam logic [2:0] PH_SECOND  = 3'd1;
    localparam logic [2:0] PH_SKIP    = 3'd2;
    localparam logic [2:0] PH_X       = 3'd3;
    localparam logic [2:0] PH_Y       = 3'd4;
    localparam logic [2:0] PH_DISCARD = 3'd5;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_TY   = 2'd1;
    localparam logic [1:0] KIND_RP   = 2'd2;

    typedef struct packed {
        logic               axis_pair;
        logic signed [15:0] first_value;
        logic signed [15:0] second_value;
    } rccp_result_t;

    // acc*10 + (b - 48), wrapped to 16 bits; no digit check
    function automatic logic [15:0] rccp_digit_step(input logic [15:0] acc,
                                                    input logic [7:0] b);
        logic [15:0] times_ten;
        times_ten = {acc[12:0], 3'b000} + {acc[14:0], 1'b0};
        return times_ten + {8'd0, b} - {8'd0, CH_ZERO};
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/rccp_if.sv
// Valid/ready channel interfaces for the command line parser.
// rccp_byte_if carries received bytes, rccp_result_if carries parsed axis pairs.
// No dependencies.
`default_nettype none

interface rccp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rccp_result_if;
    logic               valid;
    logic               ready;
    logic               axis_pair;
    logic signed [15:0] first_value;
    logic signed [15:0] second_value;

    modport source (output valid, output axis_pair, output first_value,
                    output second_value, input ready);
    modport sink   (input valid, input axis_pair, input first_value,
                    input second_value, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rccp_parser.sv
// Line parser state: phase, line kind and the two decimal accumulators.
// Depends on rccp_pkg.
`default_nettype none

module rccp_parser (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [7:0]            rx_byte,
    output logic                       emit,
    output rccp_pkg::rccp_result_t     result
);
    import rccp_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic [1:0]  kind_reg,  kind_next;
    logic [15:0] x_reg, x_next;
    logic [15:0] y_reg, y_next;

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        emit       = 1'b0;
        if (step)
        begin
            if (rx_byte == CH_NEWLINE)
            begin
                emit       = (phase_reg == PH_Y);
                phase_next = PH_FIRST;
                kind_next  = KIND_NONE;
                x_next     = 16'd0;
                y_next     = 16'd0;
            end
            else
            begin
                case (phase_reg)
                    PH_FIRST:
                    begin
                        if (rx_byte == CH_T)
                        begin
                            kind_next  = KIND_TY;
                            phase_next = PH_SECOND;
                        end
                        else if (rx_byte == CH_R)
                        begin
                            kind_next  = KIND_RP;
                            phase_next = PH_SECOND;
                        end
                        else
                        begin
                            kind_next  = KIND_NONE;
                            phase_next = PH_DISCARD;
                        end
                    end
                    PH_SECOND:
                    begin
                        if ((kind_reg == KIND_TY && rx_byte == CH_Y) ||
                            (kind_reg == KIND_RP && rx_byte == CH_P))
                            phase_next = PH_SKIP;
                        else
                            phase_next = PH_DISCARD;
                    end
                    PH_SKIP:
                    begin
                        x_next     = 16'd0;
                        phase_next = PH_X;
                    end
                    PH_X:
                    begin
                        if (rx_byte == CH_Y)
                        begin
                            y_next     = 16'd0;
                            phase_next = PH_Y;
                        end
                        else
                            x_next = rccp_digit_step(x_reg, rx_byte);
                    end
                    PH_Y:
                        y_next = rccp_digit_step(y_reg, rx_byte);
                    default:
                        phase_next = PH_DISCARD;
                endcase
            end
        end
    end

    assign result.axis_pair    = (kind_reg == KIND_RP);
    assign result.first_value  = x_reg + FIRST_OFFSET;
    assign result.second_value = SECOND_BASE - y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            kind_reg  <= KIND_NONE;
            x_reg     <= 16'd0;
            y_reg     <= 16'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rc_command_line_parser_unit.sv
// Top level of the remote-control command line parser.
// Depends on rccp_pkg, rccp_if.sv and rccp_parser.
`default_nettype none

// Takes one received byte per transfer on rx and parses newline-terminated
// lines "TY" c x-digits "Y" y-digits (axis_pair 0, yaw/throttle) and
// "RP" c x-digits "Y" y-digits (axis_pair 1, roll/pitch). The third byte is
// skipped; digits are accumulated as acc*10 + (byte - 48) modulo 2^16 with no
// check. On the newline of a complete line one result transfer on cmd carries
// first_value = x + 1000 and second_value = 2000 - y, both wrapped to 16 bits.
// Lines with another prefix, or that end before the 'Y', give no result.
// Rate: one byte per cycle unless rx stalls. Each byte is parsed in the cycle it is accepted;
// a result is loaded into the output register at the same edge that takes the
// newline, so cmd.valid rises in the cycle after that transfer. rx stalls only
// while that output register holds a result that cmd has not taken.
module rc_command_line_parser_unit (
    input  wire logic      clk,
    input  wire logic      rst_n,
    rccp_byte_if.sink      rx,
    rccp_result_if.source  cmd
);
    import rccp_pkg::*;

    logic         out_valid_reg, out_valid_next;
    rccp_result_t out_data_reg;
    logic         step;
    logic         emit;
    rccp_result_t parsed;

    // Accept a byte whenever the output register is empty or drains this cycle.
    assign rx.ready = !out_valid_reg || cmd.ready;
    assign step     = rx.valid && rx.ready;

    rccp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (rx.rx_byte),
        .emit    (emit),
        .result  (parsed)
    );

    // Hold the result until cmd takes it; load a new one on a completed line.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.ready)
            out_valid_next = 1'b0;
        if (emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_data_reg <= parsed;
    end

    assign cmd.valid        = out_valid_reg;
    assign cmd.axis_pair    = out_data_reg.axis_pair;
    assign cmd.first_value  = out_data_reg.first_value;
    assign cmd.second_value = out_data_reg.second_value;

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Testbench for rc_command_line_parser_unit: byte stream in, axis pair commands out.
// Depends on rccp_pkg and the rccp_byte_if / rccp_result_if interfaces in rtl/core.
`timescale 1ns / 100ps

module testbench;

    import rccp_pkg::*;

    localparam int HOLD_OFF_CYCLES = 180;
    localparam int RANDOM_BYTES    = 320;

    logic clk;
    logic rst_n;

    rccp_byte_if   rx_if ();
    rccp_result_if cmd_if ();

    rc_command_line_parser_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .cmd   (cmd_if)
    );

    // Shadow copy of the line parser state, advanced on every accepted byte.
    logic [2:0]  parse_phase;
    logic [1:0]  parse_kind;
    logic [15:0] x_value;
    logic [15:0] y_value;

    // Commands the parser owes us, oldest first.
    rccp_result_t expected_commands[$];

    int  error_count;
    int  bytes_sent;
    bit  rx_gaps;
    bit  cmd_gaps;
    bit  hold_off_start;

    always #2 clk = ~clk;

    // acc*10 + (b - '0'), kept to 16 bits; any byte value is taken as a digit.
    function automatic logic [15:0] next_decimal(input logic [15:0] acc,
                                                 input logic [7:0] b);
        logic [31:0] wide;
        wide = {16'd0, acc} * 32'd10 + {24'd0, b} - {24'd0, CH_ZERO};
        return wide[15:0];
    endfunction

    // Any byte except the line terminator.
    function automatic logic [7:0] pick_other_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 254));
        if (b >= CH_NEWLINE)
            b = b + 8'd1;
        return b;
    endfunction

    // Any byte except the terminator and the x/y separator.
    function automatic logic [7:0] pick_x_byte();
        logic [7:0] b;
        b = pick_other_byte();
        while (b == CH_Y)
            b = pick_other_byte();
        return b;
    endfunction

    function automatic logic [7:0] pick_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Advance the shadow parser by one byte; queue a command on the newline
    // of a complete line.
    task automatic track_line_byte(input logic [7:0] b);
        rccp_result_t cmd;
        if (b == CH_NEWLINE)
        begin
            if (parse_phase == PH_Y)
            begin
                cmd.axis_pair    = (parse_kind == KIND_RP);
                cmd.first_value  = x_value + FIRST_OFFSET;
                cmd.second_value = SECOND_BASE - y_value;
                expected_commands.push_back(cmd);
            end
            parse_phase = PH_FIRST;
            parse_kind  = KIND_NONE;
            x_value     = '0;
            y_value     = '0;
        end
        else
        begin
            case (parse_phase)
                PH_FIRST:
                begin
                    if (b == CH_T)
                        parse_kind = KIND_TY;
                    else if (b == CH_R)
                        parse_kind = KIND_RP;
                    else
                        parse_kind = KIND_NONE;
                    parse_phase = (parse_kind != KIND_NONE) ? PH_SECOND
                                                             : PH_DISCARD;
                end
                PH_SECOND:
                begin
                    if ((parse_kind == KIND_TY && b == CH_Y) ||
                        (parse_kind == KIND_RP && b == CH_P))
                        parse_phase = PH_SKIP;
                    else
                        parse_phase = PH_DISCARD;
                end
                PH_SKIP:
                begin
                    // third byte is dropped whatever it is
                    x_value     = '0;
                    parse_phase = PH_X;
                end
                PH_X:
                begin
                    if (b == CH_Y)
                    begin
                        y_value     = '0;
                        parse_phase = PH_Y;
                    end
                    else
                    begin
                        x_value = next_decimal(x_value, b);
                    end
                end
                PH_Y:
                begin
                    y_value = next_decimal(y_value, b);
                end
                default:
                begin
                    parse_phase = PH_DISCARD;
                end
            endcase
        end
    endtask

    // Offer one byte on rx and hold it until the transfer happens. Called
    // right after a rising edge; the only assignment to valid in this step
    // is the one below, so back-to-back bytes keep valid high. Ready only
    // changes at rising edges, so sample it at the falling edge before the
    // edge that would take the byte.
    task automatic send_byte(input logic [7:0] b);
        bit taken;
        while (rx_gaps && $urandom_range(0, 99) < 27)
        begin
            rx_if.valid   <= 1'b0;
            rx_if.rx_byte <= 8'($urandom_range(0, 255));
            @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = rx_if.ready;
            @(posedge clk);
        end
        track_line_byte(b);
        bytes_sent++;
    endtask

    task automatic send_line(input logic [7:0] text[$]);
        foreach (text[i])
            send_byte(text[i]);
    endtask

    // Compare one accepted command with the oldest one owed.
    task automatic check_command();
        rccp_result_t want;
        if (expected_commands.size() == 0)
        begin
            $display("%0t: unexpected command: expected none, actual %0d %0d %0d",
                     $time, cmd_if.axis_pair, cmd_if.first_value,
                     cmd_if.second_value);
            error_count++;
        end
        else
        begin
            want = expected_commands.pop_front();
            if (cmd_if.axis_pair !== want.axis_pair)
            begin
                $display("%0t: axis_pair mismatch: expected %0d, actual %0d",
                         $time, want.axis_pair, cmd_if.axis_pair);
                error_count++;
            end
            if (cmd_if.first_value !== want.first_value)
            begin
                $display("%0t: first_value mismatch: expected %0d, actual %0d",
                         $time, want.first_value, cmd_if.first_value);
                error_count++;
            end
            if (cmd_if.second_value !== want.second_value)
            begin
                $display("%0t: second_value mismatch: expected %0d, actual %0d",
                         $time, want.second_value, cmd_if.second_value);
                error_count++;
            end
        end
    endtask

    // Command receiver: at the falling edge check a transfer that the next
    // rising edge will complete, then pick the next ready at that rising
    // edge. A hold-off request parks ready low for a counted stretch.
    initial
    begin
        int hold_left;
        hold_left    = 0;
        cmd_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n && cmd_if.valid && cmd_if.ready)
                check_command();
            @(posedge clk);
            if (hold_off_start)
                hold_left = HOLD_OFF_CYCLES;
            if (hold_left > 0)
            begin
                hold_left--;
                cmd_if.ready <= 1'b0;
            end
            else
            begin
                cmd_if.ready <= !(cmd_gaps && $urandom_range(0, 99) < 27);
            end
        end
    end

    // One random line: mostly well-formed commands with random content, the
    // rest cut short, misspelled or plain noise.
    task automatic send_random_line();
        int shape;
        int count;
        logic [7:0] b;
        shape = $urandom_range(0, 99);
        if (shape < 75)
        begin
            if ($urandom_range(0, 1))
            begin
                send_byte(CH_T);
                send_byte(CH_Y);
            end
            else
            begin
                send_byte(CH_R);
                send_byte(CH_P);
            end
            send_byte(pick_other_byte());
            // mostly short numbers, now and then long enough to wrap
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 9)
                                                : $urandom_range(0, 4);
            repeat (count)
                send_byte(($urandom_range(0, 9) == 0) ? pick_x_byte() : pick_digit());
            send_byte(CH_Y);
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 9)
                                                : $urandom_range(0, 4);
            repeat (count)
                send_byte(($urandom_range(0, 9) == 0) ? pick_other_byte() : pick_digit());
        end
        else if (shape < 85)
        begin
            // good prefix, cut somewhere before the separator
            b = $urandom_range(0, 1) ? CH_T : CH_R;
            send_byte(b);
            count = $urandom_range(0, 4);
            if (count > 0)
                send_byte((b == CH_T) ? CH_Y : CH_P);
            if (count > 1)
                send_byte(pick_other_byte());
            repeat (count - 2)
                send_byte(pick_x_byte());
        end
        else if (shape < 92)
        begin
            // first letter good, second wrong, rest looks like a command
            if ($urandom_range(0, 1))
            begin
                send_byte(CH_T);
                b = pick_other_byte();
                send_byte((b == CH_Y) ? CH_P : b);
            end
            else
            begin
                send_byte(CH_R);
                b = pick_other_byte();
                send_byte((b == CH_P) ? CH_Y : b);
            end
            send_byte(pick_digit());
            send_byte(pick_digit());
            send_byte(CH_Y);
            send_byte(pick_digit());
        end
        else
        begin
            repeat ($urandom_range(0, 8))
                send_byte(pick_other_byte());
        end
        send_byte(CH_NEWLINE);
    endtask

    // Corner lines: empty line, both prefixes, 'Y' as the skipped byte,
    // non-digit bytes in both numbers including 0x00 and 0xFF, a 'Y' inside
    // y, an unknown prefix, a wrong second letter and a line that ends before the 'Y'.
    task automatic test_directed_lines();
        rx_gaps  = 1'b0;
        cmd_gaps = 1'b0;
        send_line('{CH_NEWLINE});
        send_line('{CH_T, CH_Y, CH_Y, CH_Y, CH_NEWLINE});
        send_line('{CH_R, CH_P, 8'hFF, 8'h00, CH_Y, 8'hFF, CH_Y, CH_NEWLINE});
        send_line('{8'h51, 8'h31, CH_Y, CH_NEWLINE});
        send_line('{CH_T, CH_P, CH_NEWLINE});
        send_line('{CH_T, CH_Y, 8'h35, CH_NEWLINE});
    endtask

    // Random lines; the first stretch runs with no idling on either side.
    task automatic test_random_lines();
        int stop_at;
        stop_at  = bytes_sent + RANDOM_BYTES;
        rx_gaps  = 1'b0;
        cmd_gaps = 1'b0;
        while (bytes_sent < stop_at - RANDOM_BYTES + 120)
            send_random_line();
        rx_gaps  = 1'b1;
        cmd_gaps = 1'b1;
        while (bytes_sent < stop_at)
            send_random_line();
    endtask

    // Park the receiver while well-formed lines keep arriving, so the
    // output register fills and rx stalls.
    task automatic test_command_backpressure();
        rx_gaps = 1'b0;
        hold_off_start <= 1'b1;
        @(posedge clk);
        hold_off_start <= 1'b0;
        repeat (12)
        begin
            send_line('{CH_R, CH_P, pick_other_byte(), pick_digit(), pick_digit(),
                        CH_Y, pick_digit(), pick_digit(), pick_digit(), CH_NEWLINE});
        end
        rx_gaps = 1'b1;
        repeat (6)
            send_random_line();
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = '0;
        hold_off_start = 1'b0;
        rx_gaps        = 1'b0;
        cmd_gaps       = 1'b0;
        error_count    = 0;
        bytes_sent     = 0;
        parse_phase    = PH_FIRST;
        parse_kind     = KIND_NONE;
        x_value        = '0;
        y_value        = '0;

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;

        test_directed_lines();
        test_random_lines();
        test_command_backpressure();

        // Stop offering, drain what is owed, then let the output settle.
        rx_if.valid <= 1'b0;
        while (expected_commands.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("%0t: timeout, %0d commands still owed", $time, expected_commands.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
